[rtl/core/palette_expand_integer_upscale_defines.svh]
// Assertion macros for the palette expander and its port checker.
// Needs nothing else; the including file provides the clock and reset names.
`ifndef PALETTE_EXPAND_INTEGER_UPSCALE_DEFINES_SVH
`define PALETTE_EXPAND_INTEGER_UPSCALE_DEFINES_SVH

// Property checked only while reset is released.
`define PEI_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked at every edge, reset included.
`define PEI_ASSERT_ALWAYS(label, clk, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/core/pei_pkg.sv]
// Shared types, codes and the color packing function of the palette expander.
// No dependencies; used by the interfaces, the top level and the checker.
`default_nettype none

package pei_pkg;

	localparam int PaletteDepth = 256;
	localparam int ColorW = 16;

	typedef logic [ColorW-1:0] color_t;

	typedef enum logic [1:0] {
		MODE_PALETTE = 2'd0,
		MODE_PIXEL   = 2'd1,
		MODE_REPLAY  = 2'd2
	} mode_t;

	// Truncate an RGB888 color to RGB565 by dropping the low bits of each component.
	function automatic color_t to_rgb565(input logic [7:0] r, input logic [7:0] g,
		input logic [7:0] b);
		return {r[7:3], g[7:2], b[7:3]};
	endfunction

endpackage

`default_nettype wire

[rtl/core/pei_if.sv]
// Valid/ready channel interfaces of the palette expander: item input and pixel output.
// Depends on pei_pkg for the color type.
`default_nettype none

interface pei_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] mode;
	logic [7:0] entry;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;
	logic [7:0] pixel_index;

	modport source (output valid, mode, entry, red, green, blue, pixel_index, input ready);
	modport sink   (input valid, mode, entry, red, green, blue, pixel_index, output ready);
endinterface

interface pei_out_if;
	logic            valid;
	logic            ready;
	pei_pkg::color_t color;
	logic            last;
	logic            row_end;

	modport source (output valid, color, last, row_end, input ready);
	modport sink   (input valid, color, last, row_end, output ready);
endinterface

`default_nettype wire

[rtl/core/palette_expand_integer_upscale.sv]
// Palette expander with integer nearest-neighbor upscaling.
// Depends on pei_pkg and on the channel interfaces in pei_if.sv.
//
// Usage:
// The item channel carries one beat per host command. A palette write (mode 0)
// stores the RGB565 truncation of red/green/blue at the given entry and produces
// no output. A source pixel (mode 1) looks up pixel_index, keeps the color in the
// line store at the running write column and produces SCALE output beats. A replay
// (mode 2) produces SCALE beats of the line-store color at the running replay
// column; the host sends SCALE-1 rows of replays after each source row to get the
// vertical copies. Mode 3 is accepted and ignored.
// The pixel channel carries one beat per horizontal copy: last marks the final copy
// of an item and row_end marks copies of the last column of a row.
// The first beat of an item passes the lookup stage and the output register before it
// is offered. A pixel or replay item holds the output register for one beat per copy,
// so the single output port sets the sustained rate of pixel and replay items; palette
// writes and ignored items are done at intake and never enter the lookup stage.
// One item waits in the lookup stage while the output register drains, so intake
// continues while a finished beat is stalled. When the receiver stalls, the beat on
// the pixel channel holds and intake stops once the lookup stage is also full.
// Reset clears both column counters and empties the pipeline; palette and line
// store contents are undefined until written.
`default_nettype none

module palette_expand_integer_upscale #(
	parameter int LINE_WIDTH = 240,
	parameter int SCALE = 3
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	pei_in_if.sink     item,
	pei_out_if.source  pixel
);

	localparam int ColW = (LINE_WIDTH > 1) ? $clog2(LINE_WIDTH) : 1;
	localparam int CntW = (SCALE > 1) ? $clog2(SCALE) : 1;
	localparam logic [ColW-1:0] LastCol = ColW'(LINE_WIDTH - 1);
	localparam logic [CntW-1:0] LastCopy = CntW'(SCALE - 1);

	typedef logic [ColW-1:0] col_t;

	// Storage: the palette is indexed by a full byte, the line store by column.
	pei_pkg::color_t palette_mem [pei_pkg::PaletteDepth];
	pei_pkg::color_t line_mem [LINE_WIDTH];

	// Column counters.
	col_t write_col_q;
	col_t replay_col_q;

	// Lookup stage.
	logic            valid_s1;
	logic            is_pixel_s1;
	logic            row_end_s1;
	col_t            col_s1;
	pei_pkg::color_t pal_data_s1;
	pei_pkg::color_t line_data_s1;
	logic            fwd_s1;
	pei_pkg::color_t fwd_color_s1;
	pei_pkg::color_t color_s1;

	// Output register and copy counter.
	logic            out_valid_q;
	pei_pkg::color_t color_q;
	logic            row_end_q;
	logic [CntW-1:0] cnt_q;

	logic accept;
	logic is_wr;
	logic is_pix;
	logic is_rep;
	logic enter_s1;
	logic out_free;
	logic s1_go;
	logic last_copy;

	function automatic col_t next_col(input col_t col);
		return (col == LastCol) ? '0 : col + 1'b1;
	endfunction

	// Decode the command of the offered item.
	always_comb begin
		is_wr  = 1'b0;
		is_pix = 1'b0;
		is_rep = 1'b0;
		case (item.mode)
			pei_pkg::MODE_PALETTE: begin
				is_wr = 1'b1;
			end
			pei_pkg::MODE_PIXEL: begin
				is_pix = 1'b1;
			end
			pei_pkg::MODE_REPLAY: begin
				is_rep = 1'b1;
			end
			default: begin
				is_wr = 1'b0;
			end
		endcase
	end

	// The output register is free when it is empty or its final copy leaves now.
	// The lookup stage moves on whenever the output register can take it, so a
	// new item can enter the lookup stage at the same edge.
	assign last_copy  = (cnt_q == LastCopy);
	assign out_free   = !out_valid_q || (pixel.ready && last_copy);
	assign s1_go      = valid_s1 && out_free;
	assign item.ready = !valid_s1 || out_free;
	assign accept     = item.valid && item.ready;
	assign enter_s1   = accept && (is_pix || is_rep);

	// Palette: writes land at acceptance, so a lookup accepted later always sees them.
	always_ff @(posedge clk) begin
		if (accept && is_wr) begin
			palette_mem[item.entry] <= pei_pkg::to_rgb565(item.red, item.green, item.blue);
		end
		if (accept && is_pix) begin
			pal_data_s1 <= palette_mem[item.pixel_index];
		end
	end

	// Line store: a source pixel is written as it leaves the lookup stage. A replay
	// read at that same edge of the same column misses that write, which the
	// forwarding path below covers.
	always_ff @(posedge clk) begin
		if (s1_go && is_pixel_s1) begin
			line_mem[col_s1] <= pal_data_s1;
		end
		if (accept && is_rep) begin
			line_data_s1 <= line_mem[replay_col_q];
		end
	end

	// Lookup stage payload.
	always_ff @(posedge clk) begin
		if (enter_s1) begin
			is_pixel_s1  <= is_pix;
			col_s1       <= is_pix ? write_col_q : replay_col_q;
			row_end_s1   <= is_pix ? (write_col_q == LastCol) : (replay_col_q == LastCol);
			fwd_s1       <= is_rep && valid_s1 && is_pixel_s1 && (col_s1 == replay_col_q);
			fwd_color_s1 <= pal_data_s1;
		end
	end

	assign color_s1 = is_pixel_s1 ? pal_data_s1 : (fwd_s1 ? fwd_color_s1 : line_data_s1);

	// Control state: column counters, stage occupancy and copy counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			write_col_q  <= '0;
			replay_col_q <= '0;
			valid_s1     <= 1'b0;
			out_valid_q  <= 1'b0;
			cnt_q        <= '0;
		end else begin
			if (accept && is_pix) begin
				write_col_q <= next_col(write_col_q);
			end
			if (accept && is_rep) begin
				replay_col_q <= next_col(replay_col_q);
			end

			if (enter_s1) begin
				valid_s1 <= 1'b1;
			end else if (s1_go) begin
				valid_s1 <= 1'b0;
			end

			if (s1_go) begin
				out_valid_q <= 1'b1;
				cnt_q       <= '0;
			end else if (out_valid_q && pixel.ready) begin
				if (last_copy) begin
					out_valid_q <= 1'b0;
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
		end
	end

	// Output payload.
	always_ff @(posedge clk) begin
		if (s1_go) begin
			color_q   <= color_s1;
			row_end_q <= row_end_s1;
		end
	end

	assign pixel.valid   = out_valid_q;
	assign pixel.color   = color_q;
	assign pixel.last    = last_copy;
	assign pixel.row_end = row_end_q;

endmodule

`default_nettype wire

[rtl/core/pei_chk.sv]
// Port checker for the palette expander, attached to the top level by bind.
// Depends on pei_pkg and on the assertion macros in the defines header.
`default_nettype none

`include "palette_expand_integer_upscale_defines.svh"

module pei_chk (
	input wire logic            clk,
	input wire logic            arst_n,
	input wire logic            item_valid,
	input wire logic            item_ready,
	input wire logic [1:0]      item_mode,
	input wire logic            pixel_valid,
	input wire logic            pixel_ready,
	input wire pei_pkg::color_t pixel_color,
	input wire logic            pixel_last,
	input wire logic            pixel_row_end
);

	// Nothing is offered while reset is asserted.
	`PEI_ASSERT_ALWAYS(a_reset_idle, clk, !arst_n |-> !pixel_valid, "output valid during reset")

	// A stalled beat keeps its payload.
	`PEI_ASSERT(a_stall_hold, clk, arst_n, pixel_valid && !pixel_ready |=> pixel_valid && $stable(pixel_color) && $stable(pixel_last) && $stable(pixel_row_end), "stalled beat changed")

	// Every copy but the last is followed at once by another copy of the same color.
	`PEI_ASSERT(a_copy_repeat, clk, arst_n, pixel_valid && pixel_ready && !pixel_last |=> pixel_valid && $stable(pixel_color) && $stable(pixel_row_end), "copy run broken")

	// A source pixel taken with the output empty is offered after lookup and output.
	`PEI_ASSERT(a_pixel_latency, clk, arst_n, item_valid && item_ready && (item_mode == pei_pkg::MODE_PIXEL) && !pixel_valid |-> ##2 pixel_valid, "pixel latency exceeded")

endmodule

bind palette_expand_integer_upscale pei_chk u_pei_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.item_valid    (item.valid),
	.item_ready    (item.ready),
	.item_mode     (item.mode),
	.pixel_valid   (pixel.valid),
	.pixel_ready   (pixel.ready),
	.pixel_color   (pixel.color),
	.pixel_last    (pixel.last),
	.pixel_row_end (pixel.row_end)
);

`default_nettype wire

[bench/palette_expand_integer_upscale_test.sv]
// Self-checking bench for the palette expander with integer upscaling.
// Uses pei_pkg, the channel interfaces in pei_if.sv and palette_expand_integer_upscale.
`default_nettype none

module palette_expand_integer_upscale_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LineWidth = 240;
	localparam int Scale = 3;
	// Mode 3 has no member in the package; the block accepts it and does nothing.
	localparam logic [1:0] ModeUnused = 2'd3;
	localparam int DirectedRows = 22;
	localparam int RandomItems = 148;

	// One input beat. A pinned row carries a color that is plain at a glance and
	// replaces the predicted color for every copy that the beat produces.
	typedef struct {
		logic [1:0]      mode;
		logic [7:0]      entry;
		logic [7:0]      red;
		logic [7:0]      green;
		logic [7:0]      blue;
		logic [7:0]      index;
		logic            pinned;
		pei_pkg::color_t color;
	} stim_row_t;

	// One output beat as the pixel channel should present it.
	typedef struct {
		pei_pkg::color_t color;
		logic            last;
		logic            row_end;
	} pixel_beat_t;

	logic clk;
	logic arst_n;

	pei_in_if  item_ch ();
	pei_out_if pix_ch ();

	palette_expand_integer_upscale #(
		.LINE_WIDTH(LineWidth),
		.SCALE(Scale)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.item(item_ch),
		.pixel(pix_ch)
	);

	// Shadow state of the block, updated at the edge where an item beat is taken.
	pei_pkg::color_t shadow_palette [pei_pkg::PaletteDepth];
	pei_pkg::color_t shadow_line [LineWidth];
	int              shadow_wcol;
	int              shadow_rcol;

	// Pixel beats still owed by the block, oldest first.
	pixel_beat_t pending_beats [$];

	// What the sending side has committed to so far. Used to keep the stimulus away
	// from palette entries and line-store columns that hold nothing yet.
	bit host_palette_set [pei_pkg::PaletteDepth];
	bit host_line_set [LineWidth];
	int host_wcol;
	int host_rcol;

	// Pinned color travelling alongside the item beat on the bench side.
	logic            pin_valid;
	pei_pkg::color_t pin_color;

	int  items_taken;
	int  failures;
	// While set, neither side inserts idle cycles.
	bit  calm;

	stim_row_t directed [DirectedRows];

	initial clk = 1'b0;
	always #1 clk = ~clk;

	// Upper bound on the whole run. The slowest legal run, with every beat waiting out
	// long receiver stalls, stays far below this.
	initial begin
		#500us;
		$display("Regression FAIL");
		$finish;
	end

	// Receiver: stalls in roughly a quarter of the cycles unless a calm stretch runs.
	always @(negedge clk) pix_ch.ready = calm || ($urandom_range(99) >= 26);

	// Column counters count 0..LineWidth-1 and wrap back to zero.
	function automatic int next_col(input int col);
		return (col + 1 >= LineWidth) ? 0 : col + 1;
	endfunction

	// Predicts the beats caused by one accepted item and advances the shadow state.
	// A palette write stores the truncated color and owes nothing; mode 3 is ignored.
	function automatic void expand_item(input logic [1:0] mode, input logic [7:0] entry,
		input logic [7:0] red, input logic [7:0] green, input logic [7:0] blue,
		input logic [7:0] index, input logic pinned, input pei_pkg::color_t pinned_color);
		pei_pkg::color_t shade;
		int              col;
		pixel_beat_t     beat;
		if (mode == pei_pkg::MODE_PALETTE) begin
			shadow_palette[entry] = {red[7:3], green[7:2], blue[7:3]};
			return;
		end
		if (mode == pei_pkg::MODE_PIXEL) begin
			col = shadow_wcol;
			shade = shadow_palette[index];
			shadow_line[col] = shade;
			shadow_wcol = next_col(col);
		end else if (mode == pei_pkg::MODE_REPLAY) begin
			col = shadow_rcol;
			shade = shadow_line[col];
			shadow_rcol = next_col(col);
		end else begin
			return;
		end
		// Each horizontal copy is one beat; only the final copy carries last.
		for (int k = 0; k < Scale; k++) begin
			beat.color = pinned ? pinned_color : shade;
			beat.last = (k == Scale - 1);
			beat.row_end = (col == LineWidth - 1);
			pending_beats.push_back(beat);
		end
	endfunction

	// Monitor on both channels. Prediction runs before the output check so that even
	// a beat leaving in the same cycle as its item would find its expectation queued.
	always @(posedge clk) begin
		pixel_beat_t want;
		if (arst_n) begin
			if (item_ch.valid && item_ch.ready) begin
				expand_item(item_ch.mode, item_ch.entry, item_ch.red, item_ch.green,
					item_ch.blue, item_ch.pixel_index, pin_valid, pin_color);
				items_taken <= items_taken + 1;
			end
			if (pix_ch.valid && pix_ch.ready) begin
				if (pending_beats.size() == 0) begin
					$error("pixel beat with nothing expected: color %h last %b row_end %b",
						pix_ch.color, pix_ch.last, pix_ch.row_end);
					failures++;
				end else begin
					want = pending_beats.pop_front();
					if (pix_ch.color !== want.color) begin
						$error("color: expected %h, got %h", want.color, pix_ch.color);
						failures++;
					end
					if (pix_ch.last !== want.last) begin
						$error("last: expected %b, got %b", want.last, pix_ch.last);
						failures++;
					end
					if (pix_ch.row_end !== want.row_end) begin
						$error("row_end: expected %b, got %b", want.row_end, pix_ch.row_end);
						failures++;
					end
				end
			end
		end
	end

	// Sender-side bookkeeping, done when a beat is put on the channel. Beats are taken
	// in order, so this runs ahead of the shadow state but in the same sequence.
	function automatic void note_host(input stim_row_t row);
		case (row.mode)
			pei_pkg::MODE_PALETTE: begin
				host_palette_set[row.entry] = 1'b1;
			end
			pei_pkg::MODE_PIXEL: begin
				host_line_set[host_wcol] = 1'b1;
				host_wcol = next_col(host_wcol);
			end
			pei_pkg::MODE_REPLAY: begin
				host_rcol = next_col(host_rcol);
			end
			default: begin
			end
		endcase
	endfunction

	// Puts one beat on the item channel and returns at the falling edge after it was
	// taken, so the next beat can follow without a gap.
	task automatic send_item(input stim_row_t row);
		int seen;
		while (!calm && $urandom_range(99) < 26) begin
			item_ch.valid = 1'b0;
			@(negedge clk);
		end
		item_ch.valid = 1'b1;
		item_ch.mode = row.mode;
		item_ch.entry = row.entry;
		item_ch.red = row.red;
		item_ch.green = row.green;
		item_ch.blue = row.blue;
		item_ch.pixel_index = row.index;
		pin_valid = row.pinned;
		pin_color = row.color;
		note_host(row);
		seen = items_taken;
		do @(negedge clk); while (items_taken == seen);
	endtask

	// Random host traffic. Replays are as likely as source pixels whenever the replay
	// column points at a column that has been filled, which keeps the replay column close
	// behind the write column and exercises reads of freshly written columns. Pixel indices
	// only name palette entries that were written. Fields that a mode ignores stay random.
	function automatic stim_row_t next_random_item();
		stim_row_t row;
		int        roll;
		row.entry = $urandom_range(255);
		row.red = $urandom_range(255);
		row.green = $urandom_range(255);
		row.blue = $urandom_range(255);
		row.index = $urandom_range(255);
		row.pinned = 1'b0;
		row.color = '0;
		roll = $urandom_range(99);
		if (roll < 8) begin
			row.mode = pei_pkg::MODE_PALETTE;
		end else if (roll < 10) begin
			row.mode = ModeUnused;
		end else if (roll < 55 && host_line_set[host_rcol]) begin
			row.mode = pei_pkg::MODE_REPLAY;
		end else begin
			row.mode = pei_pkg::MODE_PIXEL;
			while (!host_palette_set[row.index]) row.index = $urandom_range(255);
		end
		return row;
	endfunction

	initial begin
		stim_row_t row;
		int        n;

		arst_n = 1'b0;
		calm = 1'b0;
		items_taken = 0;
		failures = 0;
		shadow_wcol = 0;
		shadow_rcol = 0;
		host_wcol = 0;
		host_rcol = 0;
		item_ch.valid = 1'b0;
		item_ch.mode = pei_pkg::MODE_PALETTE;
		item_ch.entry = '0;
		item_ch.red = '0;
		item_ch.green = '0;
		item_ch.blue = '0;
		item_ch.pixel_index = '0;
		pix_ch.ready = 1'b0;
		pin_valid = 1'b0;
		pin_color = '0;

		// Directed rows. Colors are typed in where the truncation is obvious: black,
		// white, the pure primaries, and a color whose set bits all fall below the
		// kept ones. The mixed color is left to the predictor.
		directed = '{
			'{pei_pkg::MODE_PALETTE, 8'd0,   8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 16'h0000},
			'{pei_pkg::MODE_PALETTE, 8'd255, 8'hFF, 8'hFF, 8'hFF, 8'h00, 1'b0, 16'h0000},
			'{pei_pkg::MODE_PALETTE, 8'd1,   8'hFF, 8'h00, 8'h00, 8'h00, 1'b0, 16'h0000},
			'{pei_pkg::MODE_PALETTE, 8'd2,   8'h00, 8'hFF, 8'h00, 8'h00, 1'b0, 16'h0000},
			'{pei_pkg::MODE_PALETTE, 8'd3,   8'h00, 8'h00, 8'hFF, 8'h00, 1'b0, 16'h0000},
			'{pei_pkg::MODE_PALETTE, 8'd4,   8'h07, 8'h03, 8'h07, 8'h00, 1'b0, 16'h0000},
			'{pei_pkg::MODE_PALETTE, 8'd5,   8'hA5, 8'h5A, 8'hC3, 8'h00, 1'b0, 16'h0000},
			// Source pixels fill columns 0 to 6.
			'{pei_pkg::MODE_PIXEL,   8'd0,   8'h00, 8'h00, 8'h00, 8'd0,   1'b1, 16'h0000},
			'{pei_pkg::MODE_PIXEL,   8'd0,   8'h00, 8'h00, 8'h00, 8'd255, 1'b1, 16'hFFFF},
			'{pei_pkg::MODE_PIXEL,   8'd0,   8'h00, 8'h00, 8'h00, 8'd1,   1'b1, 16'hF800},
			'{pei_pkg::MODE_PIXEL,   8'd0,   8'h00, 8'h00, 8'h00, 8'd2,   1'b1, 16'h07E0},
			'{pei_pkg::MODE_PIXEL,   8'd0,   8'h00, 8'h00, 8'h00, 8'd3,   1'b1, 16'h001F},
			'{pei_pkg::MODE_PIXEL,   8'd0,   8'h00, 8'h00, 8'h00, 8'd4,   1'b1, 16'h0000},
			'{pei_pkg::MODE_PIXEL,   8'd0,   8'h00, 8'h00, 8'h00, 8'd5,   1'b0, 16'h0000},
			// The unused mode with every field bit set must leave no trace.
			'{ModeUnused,            8'hFF,  8'hFF, 8'hFF, 8'hFF, 8'hFF,  1'b0, 16'h0000},
			// Replays walk the stored row from column 0.
			'{pei_pkg::MODE_REPLAY,  8'd0,   8'h00, 8'h00, 8'h00, 8'd0,   1'b1, 16'h0000},
			'{pei_pkg::MODE_REPLAY,  8'd0,   8'h00, 8'h00, 8'h00, 8'd0,   1'b1, 16'hFFFF},
			'{pei_pkg::MODE_REPLAY,  8'd0,   8'h00, 8'h00, 8'h00, 8'd0,   1'b1, 16'hF800},
			// A palette change of entry 1, then a replay of column 3 (stored from entry 2) and a new source pixel from entry 1.
			'{pei_pkg::MODE_PALETTE, 8'd1,   8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 16'h0000},
			'{pei_pkg::MODE_REPLAY,  8'd0,   8'h00, 8'h00, 8'h00, 8'd0,   1'b1, 16'h07E0},
			'{pei_pkg::MODE_PIXEL,   8'd0,   8'h00, 8'h00, 8'h00, 8'd1,   1'b1, 16'h0000},
			'{ModeUnused,            8'h00,  8'h00, 8'h00, 8'h00, 8'h00,  1'b0, 16'h0000}
		};

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (directed[i]) send_item(directed[i]);

		// Random part. A stretch in the middle runs with no idling on either side.
		for (n = 0; n < RandomItems; n++) begin
			calm = (n >= 60 && n < 100);
			row = next_random_item();
			send_item(row);
		end
		calm = 1'b0;
		item_ch.valid = 1'b0;
		pin_valid = 1'b0;

		// Drain, then keep watching the pixel channel to show any stray beat.
		while (pending_beats.size() != 0) @(negedge clk);
		repeat (20) @(negedge clk);

		if (failures == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

`default_nettype wire
